### sv/i2cadc_pkg.sv
package i2cadc_pkg;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_PHASE_TICKS    = 2'd1;
	localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd2;

	// configuration reset values
	localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'h48;
	localparam logic [15:0] PHASE_TICKS_RST    = 16'd600;
	localparam logic [15:0] LOW_THRESHOLD_RST  = 16'd3100;

	// command codes
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	// sequencer step codes
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ST_A = 5'd1;
	localparam logic [4:0] S_ST_B = 5'd2;
	localparam logic [4:0] S_TX_A = 5'd3;
	localparam logic [4:0] S_TX_B = 5'd4;
	localparam logic [4:0] S_TX_C = 5'd5;
	localparam logic [4:0] S_AK_A = 5'd6;
	localparam logic [4:0] S_AK_B = 5'd7;
	localparam logic [4:0] S_RX_A = 5'd8;
	localparam logic [4:0] S_RX_B = 5'd9;
	localparam logic [4:0] S_MA_A = 5'd10;
	localparam logic [4:0] S_MA_B = 5'd11;
	localparam logic [4:0] S_MA_C = 5'd12;
	localparam logic [4:0] S_SP_A = 5'd13;
	localparam logic [4:0] S_SP_B = 5'd14;
	localparam logic [4:0] S_SP_C = 5'd15;

	localparam logic [2:0] LAST_BIT = 3'd7;

	// one result word
	typedef struct packed {
		logic        scl;
		logic        sda_release;
		logic        busy_res;
		logic        done_res;
		logic        ack_error;
		logic [15:0] raw_code;
		logic [15:0] average;
		logic        under_threshold;
	} res_t;

endpackage

### sv/i2c_adc_reader_low_voltage.sv
// i2c adc reader: one tick word in, one result word out
// a result word is registered into the output register, or into the skid entry while the output word is stalled
// throughput: one tick word per cycle while in_stall is low; the bus sequencer updates once per word
// output register plus one skid entry; in_stall is high only while the skid is full
// reset (arst_n low, asynchronous): sequencer idle, counters, flags, average cleared,
// registers back to address 72, 600 ticks per phase, threshold 3100
module i2c_adc_reader_low_voltage
	import i2cadc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// tick channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl,
	output logic        sda_release,
	output logic        busy_res,
	output logic        done_res,
	output logic        ack_error,
	output logic [15:0] raw_code,
	output logic [15:0] average,
	output logic        under_threshold,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [6:0]  dev_addr_q;
	logic [15:0] phase_ticks_q;
	logic [15:0] low_thr_q;

	// sequencer state
	logic [15:0] tick_q;
	logic [4:0]  step_q;
	logic [2:0]  bit_q;
	logic [1:0]  byte_q;
	logic [7:0]  shift_q;
	logic        is_read_q;
	logic [7:0]  wr_byte_q;
	logic [15:0] raw_q;
	logic [15:0] avg_q;
	logic        low_q;
	logic        err_q;

	// next state
	logic [15:0] tick_d;
	logic [4:0]  step_d;
	logic [2:0]  bit_d;
	logic [1:0]  byte_d;
	logic [7:0]  shift_d;
	logic        is_read_d;
	logic [7:0]  wr_byte_d;
	logic [15:0] raw_d;
	logic [15:0] avg_d;
	logic        low_d;
	logic        err_d;

	logic        scl_o;
	logic        rel_o;
	logic        busy_o;
	logic        done_o;
	logic        last;
	logic        cur_bit;
	logic [4:0]  step_w;
	logic [7:0]  rx_shift;

	// scaling of the read code
	logic signed [15:0] code_s;
	logic signed [11:0] code_sh;
	logic signed [13:0] scaled;
	logic signed [17:0] avg_sum;
	logic [15:0]        avg_fold;

	res_t res_new;
	res_t out_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic accept;
	logic out_take;

	// apb port
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= DEVICE_ADDRESS_RST;
			phase_ticks_q <= PHASE_TICKS_RST;
			low_thr_q     <= LOW_THRESHOLD_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEVICE_ADDRESS: dev_addr_q    <= pwdata[6:0];
				REG_PHASE_TICKS:    phase_ticks_q <= pwdata[15:0];
				REG_LOW_THRESHOLD:  low_thr_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DEVICE_ADDRESS: prdata = {25'd0, dev_addr_q};
			REG_PHASE_TICKS:    prdata = {16'd0, phase_ticks_q};
			REG_LOW_THRESHOLD:  prdata = {16'd0, low_thr_q};
			default:            prdata = 32'd0;
		endcase
	end

	// fold of the freshly read code into the running average
	always_comb begin
		code_s   = signed'(raw_q);
		code_sh  = 12'(code_s >>> 4);
		scaled   = 14'(code_sh) + (14'(code_sh) <<< 1);
		avg_sum  = signed'({2'b00, avg_q}) + 18'(scaled);
		avg_fold = (avg_q == 16'd0) ? 16'(scaled) : avg_sum[16:1];
	end

	// bus sequencer, one tick
	always_comb begin
		tick_d    = tick_q;
		step_w    = (step_q > S_SP_C) ? S_IDLE : step_q;
		bit_d     = bit_q;
		byte_d    = byte_q;
		shift_d   = shift_q;
		is_read_d = is_read_q;
		wr_byte_d = wr_byte_q;
		raw_d     = raw_q;
		avg_d     = avg_q;
		low_d     = low_q;
		err_d     = err_q;
		scl_o     = 1'b1;
		rel_o     = 1'b1;
		busy_o    = 1'b0;
		done_o    = 1'b0;
		last      = 1'b0;
		rx_shift  = {shift_q[6:0], sda_in};

		// command taken only while idle
		if (step_w == S_IDLE && (mode == MODE_READ || mode == MODE_WRITE)) begin
			is_read_d = (mode == MODE_READ);
			wr_byte_d = write_data;
			shift_d   = {dev_addr_q, (mode == MODE_READ)};
			bit_d     = 3'd0;
			byte_d    = 2'd0;
			tick_d    = 16'd0;
			err_d     = 1'b0;
			step_w    = S_ST_A;
		end
		cur_bit = shift_d[7];
		step_d  = step_w;

		// bus levels of the active phase
		case (step_w)
			S_ST_A:                 begin scl_o = 1'b1; rel_o = 1'b1;    end
			S_ST_B:                 begin scl_o = 1'b1; rel_o = 1'b0;    end
			S_TX_A, S_TX_B:         begin scl_o = 1'b0; rel_o = cur_bit; end
			S_TX_C:                 begin scl_o = 1'b1; rel_o = cur_bit; end
			S_AK_A, S_RX_A, S_MA_A: begin scl_o = 1'b0; rel_o = 1'b1;    end
			S_AK_B, S_RX_B:         begin scl_o = 1'b1; rel_o = 1'b1;    end
			S_MA_B, S_SP_A:         begin scl_o = 1'b0; rel_o = 1'b0;    end
			S_MA_C, S_SP_B:         begin scl_o = 1'b1; rel_o = 1'b0;    end
			S_SP_C:                 begin scl_o = 1'b1; rel_o = 1'b1;    end
			default: ;
		endcase

		// phase timing and step transitions
		if (step_w != S_IDLE) begin
			busy_o = 1'b1;
			last   = ({1'b0, tick_d} + 17'd1) >= {1'b0, phase_ticks_q};
			if (!last) begin
				tick_d = tick_d + 16'd1;
			end else begin
				tick_d = 16'd0;
				case (step_w)
					S_TX_C: begin
						shift_d = {shift_d[6:0], 1'b0};
						if (bit_d == LAST_BIT) begin
							bit_d  = 3'd0;
							step_d = S_AK_A;
						end else begin
							bit_d  = bit_d + 3'd1;
							step_d = S_TX_A;
						end
					end
					S_AK_B: begin
						if (sda_in) begin
							err_d  = 1'b1;
							step_d = S_SP_A;
						end else if (byte_d == 2'd0 && is_read_d) begin
							shift_d = 8'd0;
							step_d  = S_RX_A;
						end else if (byte_d == 2'd0) begin
							shift_d = wr_byte_d;
							byte_d  = 2'd1;
							step_d  = S_TX_A;
						end else begin
							step_d = S_SP_A;
						end
					end
					S_RX_B: begin
						shift_d = rx_shift;
						if (bit_d == LAST_BIT) begin
							bit_d = 3'd0;
							if (byte_d == 2'd0) raw_d = {rx_shift, raw_q[7:0]};
							else raw_d = {raw_q[15:8], rx_shift};
							step_d = S_MA_A;
						end else begin
							bit_d  = bit_d + 3'd1;
							step_d = S_RX_A;
						end
					end
					S_MA_C: begin
						if (byte_d == 2'd0) begin
							byte_d  = 2'd1;
							shift_d = 8'd0;
							step_d  = S_RX_A;
						end else begin
							step_d = S_SP_A;
						end
					end
					S_SP_C: begin
						if (is_read_d && !err_d) begin
							avg_d = avg_fold;
							low_d = avg_fold < low_thr_q;
						end
						done_o = 1'b1;
						step_d = S_IDLE;
					end
					default: step_d = step_w + 5'd1;
				endcase
			end
		end

		res_new.scl             = scl_o;
		res_new.sda_release     = rel_o;
		res_new.busy_res        = busy_o;
		res_new.done_res        = done_o;
		res_new.ack_error       = err_d;
		res_new.raw_code        = raw_d;
		res_new.average         = avg_d;
		res_new.under_threshold = low_d;
	end

	// handshake
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= 16'd0;
			step_q    <= S_IDLE;
			bit_q     <= 3'd0;
			byte_q    <= 2'd0;
			shift_q   <= 8'd0;
			is_read_q <= 1'b0;
			wr_byte_q <= 8'd0;
			raw_q     <= 16'd0;
			avg_q     <= 16'd0;
			low_q     <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			tick_q    <= tick_d;
			step_q    <= step_d;
			bit_q     <= bit_d;
			byte_q    <= byte_d;
			shift_q   <= shift_d;
			is_read_q <= is_read_d;
			wr_byte_q <= wr_byte_d;
			raw_q     <= raw_d;
			avg_q     <= avg_d;
			low_q     <= low_d;
			err_q     <= err_d;
		end
	end

	// output register and skid entry, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q || out_take) out_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register and skid entry, data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) out_q <= skid_q;
		end else if (accept) begin
			if (!out_valid_q || out_take) out_q <= res_new;
			else skid_q <= res_new;
		end
	end

	assign out_valid       = out_valid_q;
	assign scl             = out_q.scl;
	assign sda_release     = out_q.sda_release;
	assign busy_res        = out_q.busy_res;
	assign done_res        = out_q.done_res;
	assign ack_error       = out_q.ack_error;
	assign raw_code        = out_q.raw_code;
	assign average         = out_q.average;
	assign under_threshold = out_q.under_threshold;

	// the skid entry only fills behind a waiting output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output word");

	// the bit counter is back at zero whenever the bus is idle or stopping
	a_bit_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_IDLE || step_q == S_SP_A || step_q == S_SP_B || step_q == S_SP_C)
		|-> bit_q == 3'd0)
		else $error("bit counter not cleared outside a byte");

	// the byte counter stays at 0 or 1: at most two data bytes per transaction
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= 2'd1)
		else $error("byte counter out of range");

	// the final stop tick returns the sequencer to idle with a done pulse
	a_stop_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step_q == S_SP_C && last) |=> (step_q == S_IDLE && out_valid_q))
		else $error("stop phase did not end the transaction");

endmodule
